### rtl/core/qpr_pkg.sv
package qpr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;
  localparam int NUM_COMP   = 4;
  localparam int NUM_TERMS  = 4;
  localparam int NUM_PROD   = NUM_COMP * NUM_TERMS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  typedef struct packed {
    data_t rot_w;
    data_t rot_x;
    data_t rot_y;
    data_t rot_z;
    data_t right_w;
    data_t right_x;
    data_t right_y;
    data_t right_z;
    data_t point_x;
    data_t point_y;
    data_t point_z;
  } in_t;

  typedef struct packed {
    data_t out_x;
    data_t out_y;
    data_t out_z;
  } out_t;

  // Hamilton product term table, component-major: w, x, y, z
  localparam logic [1:0] A_IDX [NUM_PROD] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd1,
    2'd0, 2'd3, 2'd1, 2'd2
  };

  localparam logic [1:0] B_IDX [NUM_PROD] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd2, 2'd1
  };

  localparam logic TERM_SUB [NUM_PROD] = '{
    1'b0, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1
  };

endpackage

### rtl/core/quaternion_point_rotation.sv
// Rotates a 3D point by the Hamilton products rot * (0, point) * right, all values
// signed fixed point with FRAC_BITS fraction bits; the right-hand quaternion is
// used as given and intermediate and final components saturate. One transfer is
// taken every cycle while out_ready does not stall. The pipeline has two
// multiply stages of 16 parallel 32x32 multipliers, each followed by a stage that
// adds, shifts and saturates. A stall on out_ready holds the whole pipeline.
module quaternion_point_rotation #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qpr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qpr_pkg::out_t out_data
);

  localparam int NC = qpr_pkg::NUM_COMP;

  logic en;
  logic v1_r, v2_r, v3_r, out_valid_r;

  qpr_pkg::data_t rot_q  [NC];
  qpr_pkg::data_t pnt_q  [NC];
  qpr_pkg::data_t rgt_q  [NC];
  qpr_pkg::data_t rgt1_r [NC];
  qpr_pkg::data_t rgt2_r [NC];
  qpr_pkg::data_t t_q    [NC];
  qpr_pkg::data_t u_q    [NC];
  qpr_pkg::prod_t prod1  [qpr_pkg::NUM_PROD];
  qpr_pkg::prod_t prod2  [qpr_pkg::NUM_PROD];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign rot_q = '{in_data.rot_w, in_data.rot_x, in_data.rot_y, in_data.rot_z};
  assign rgt_q = '{in_data.right_w, in_data.right_x, in_data.right_y, in_data.right_z};
  assign pnt_q = '{'0, in_data.point_x, in_data.point_y, in_data.point_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgt1_r <= rgt_q;
      rgt2_r <= rgt1_r;
    end
  end

  qpr_prod u_prod1 (
    .clk  (clk),
    .en   (en),
    .a    (rot_q),
    .b    (pnt_q),
    .prod (prod1)
  );

  qpr_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce1 (
    .clk  (clk),
    .en   (en),
    .prod (prod1),
    .q    (t_q)
  );

  qpr_prod u_prod2 (
    .clk  (clk),
    .en   (en),
    .a    (t_q),
    .b    (rgt2_r),
    .prod (prod2)
  );

  qpr_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce2 (
    .clk  (clk),
    .en   (en),
    .prod (prod2),
    .q    (u_q)
  );

  assign out_valid      = out_valid_r;
  assign out_data.out_x = u_q[1];
  assign out_data.out_y = u_q[2];
  assign out_data.out_z = u_q[3];

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transfer did not enter the pipeline");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(v2_r) && $stable(v3_r) && $stable(out_data))
    else $error("pipeline moved during a stall");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en |=> out_valid)
    else $error("last stage lost a result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !out_valid)
    else $error("valid bits not cleared by reset");
`endif

endmodule

### rtl/core/qpr_prod.sv
module qpr_prod (
  input  logic          clk,
  input  logic          en,
  input  qpr_pkg::data_t a [qpr_pkg::NUM_COMP],
  input  qpr_pkg::data_t b [qpr_pkg::NUM_COMP],
  output qpr_pkg::prod_t prod [qpr_pkg::NUM_PROD]
);

  qpr_pkg::prod_t prod_r [qpr_pkg::NUM_PROD];

  for (genvar g = 0; g < qpr_pkg::NUM_PROD; g++) begin : g_mul
    qpr_pkg::prod_t prod_nxt;
    assign prod_nxt = qpr_pkg::PROD_WIDTH'(a[qpr_pkg::A_IDX[g]])
                    * qpr_pkg::PROD_WIDTH'(b[qpr_pkg::B_IDX[g]]);
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[g] <= prod_nxt;
      end
    end
    assign prod[g] = prod_r[g];
  end

endmodule

### rtl/core/qpr_reduce.sv
module qpr_reduce #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          en,
  input  qpr_pkg::prod_t prod [qpr_pkg::NUM_PROD],
  output qpr_pkg::data_t q [qpr_pkg::NUM_COMP]
);

  localparam int DW = qpr_pkg::DATA_WIDTH;
  localparam int SW = qpr_pkg::SUM_WIDTH;
  localparam int NT = qpr_pkg::NUM_TERMS;
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic signed [SW-1:0] term [qpr_pkg::NUM_PROD];
  qpr_pkg::data_t       q_r  [qpr_pkg::NUM_COMP];

  for (genvar g = 0; g < qpr_pkg::NUM_PROD; g++) begin : g_term
    assign term[g] = qpr_pkg::TERM_SUB[g] ? -SW'(prod[g]) : SW'(prod[g]);
  end

  for (genvar c = 0; c < qpr_pkg::NUM_COMP; c++) begin : g_comp
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shr;
    qpr_pkg::data_t       q_nxt;

    assign sum = (term[NT*c] + term[NT*c+1]) + (term[NT*c+2] + term[NT*c+3]);
    assign shr = sum >>> FRAC_BITS;

    always_comb begin
      if (shr > SAT_MAX) begin
        q_nxt = SAT_MAX[DW-1:0];
      end else if (shr < SAT_MIN) begin
        q_nxt = SAT_MIN[DW-1:0];
      end else begin
        q_nxt = shr[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[c] <= q_nxt;
      end
    end
    assign q[c] = q_r[c];
  end

endmodule
